// File: hdl/http_get_request_checker_core_defines.svh
// Shared assertion macros for the request checker.
`ifndef HTTP_GET_REQUEST_CHECKER_CORE_DEFINES_SVH
`define HTTP_GET_REQUEST_CHECKER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HGRC_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// Next-cycle implication checked outside reset.
`define HGRC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

// File: hdl/hgrc_pkg.sv
`default_nettype none
package hgrc_pkg;
   typedef enum logic [1:0] {
      PH_LINE = 2'd0,
      PH_HDR  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD      = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_METHOD   = 3'd3;
   localparam logic [2:0] ST_VERSION  = 3'd4;

   localparam logic [0:0] CSR_MAX_LINE = 1'b0;
   localparam logic [0:0] CSR_MAX_HDR  = 1'b1;

   // Queue entry between the front and the response port.
   typedef struct packed {
      logic [2:0] status;
   } verdict_type;

   function automatic logic [7:0] get_char(input logic [1:0] i);
      case (i)
         2'd0: get_char = 8'h47;
         2'd1: get_char = 8'h45;
         2'd2: get_char = 8'h54;
         default: get_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] path_char(input logic [2:0] i);
      case (i)
         3'd0: path_char = 8'h2f;
         3'd1: path_char = 8'h6d;
         3'd2: path_char = 8'h65;
         3'd3: path_char = 8'h74;
         3'd4: path_char = 8'h72;
         3'd5: path_char = 8'h69;
         3'd6: path_char = 8'h63;
         default: path_char = 8'h73;
      endcase
   endfunction

   function automatic logic [7:0] proto_char(input logic [2:0] i);
      case (i)
         3'd0: proto_char = 8'h48;
         3'd1: proto_char = 8'h54;
         3'd2: proto_char = 8'h54;
         3'd3: proto_char = 8'h50;
         3'd4: proto_char = 8'h2f;
         default: proto_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: cl_char = "c";
         5'd1: cl_char = "o";
         5'd2: cl_char = "n";
         5'd3: cl_char = "t";
         5'd4: cl_char = "e";
         5'd5: cl_char = "n";
         5'd6: cl_char = "t";
         5'd7: cl_char = "-";
         5'd8: cl_char = "l";
         5'd9: cl_char = "e";
         5'd10: cl_char = "n";
         5'd11: cl_char = "g";
         5'd12: cl_char = "t";
         5'd13: cl_char = "h";
         default: cl_char = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: te_char = "t";
         5'd1: te_char = "r";
         5'd2: te_char = "a";
         5'd3: te_char = "n";
         5'd4: te_char = "s";
         5'd5: te_char = "f";
         5'd6: te_char = "e";
         5'd7: te_char = "r";
         5'd8: te_char = "-";
         5'd9: te_char = "e";
         5'd10: te_char = "n";
         5'd11: te_char = "c";
         5'd12: te_char = "o";
         5'd13: te_char = "d";
         5'd14: te_char = "i";
         5'd15: te_char = "n";
         5'd16: te_char = "g";
         default: te_char = 8'h00;
      endcase
   endfunction
endpackage
`default_nettype wire

// File: hdl/hgrc_front.sv
`default_nettype none
module hgrc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [1:0]           kind,
   input  wire logic [7:0]           data_byte,
   input  wire logic [15:0]          max_line,
   input  wire logic [15:0]          max_hdr,
   output logic                      emit,
   output hgrc_pkg::verdict_type     verdict
);
   import hgrc_pkg::*;

   localparam logic [2:0] METH_MISS = 3'd7;
   localparam logic [3:0] PATH_MISS = 4'd15;
   localparam logic [3:0] VER_OTHER = 4'd9;
   localparam logic [3:0] VER_MISS  = 4'd15;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_SP = 8'h20;

   phase_type   phase_ff, phase_in;
   logic [16:0] total_ff, total_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [1:0]  spaces_ff, spaces_in;
   logic [2:0]  meth_ff, meth_in;
   logic [3:0]  path_ff, path_in;
   logic [3:0]  ver_ff, ver_in;
   logic        bad_ff, bad_in;
   logic        lovf_ff, lovf_in;
   logic        hovf_ff, hovf_in;
   logic        cl_ff, cl_in;
   logic        te_ff, te_in;
   logic [1:0]  term_ff, term_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic        forb_ff, forb_in;

   logic [16:0] cap;
   logic [16:0] total_inc;
   logic [7:0]  low;
   logic        prev_cr, complete, line_rej, line_rej_nx;

   assign cap = {1'b0, max_line} + {1'b0, max_hdr};
   assign total_inc = (total_ff != 17'h1ffff) ? total_ff + 17'd1 : total_ff;
   assign low = (data_byte >= 8'h41 && data_byte <= 8'h5a) ? data_byte + 8'd32 : data_byte;
   assign prev_cr = term_ff[0];
   assign line_rej = bad_ff || lovf_ff || (line_ff > max_line);

   // Per-transfer state update for data, close and error, one transfer per cycle while step is high.
   always_comb begin
      phase_in = phase_ff; total_in = total_ff; line_in = line_ff; hdr_in = hdr_ff;
      spaces_in = spaces_ff; meth_in = meth_ff; path_in = path_ff; ver_in = ver_ff;
      bad_in = bad_ff; lovf_in = lovf_ff; hovf_in = hovf_ff; cl_in = cl_ff; te_in = te_ff;
      term_in = term_ff; hpos_in = hpos_ff; forb_in = forb_ff;
      emit = 1'b0; verdict.status = ST_BAD; complete = 1'b0; line_rej_nx = 1'b0;
      if (step) begin
         if (kind == KIND_CLOSE || kind == KIND_ERROR) begin
            if (phase_ff != PH_DONE) begin
               emit = 1'b1;
               if (kind == KIND_CLOSE && phase_ff == PH_HDR && !line_rej && ver_ff != 4'd8)
                  verdict.status = ST_VERSION;
            end
            phase_in = PH_LINE; total_in = '0; line_in = '0; hdr_in = '0; spaces_in = '0;
            meth_in = '0; path_in = '0; ver_in = '0; bad_in = 1'b0; lovf_in = 1'b0;
            hovf_in = 1'b0; cl_in = 1'b0; te_in = 1'b0; term_in = '0; hpos_in = '0;
            forb_in = 1'b0;
         end else if (kind == KIND_DATA && phase_ff != PH_DONE) begin
            total_in = total_inc;
            if (total_inc > cap) begin
               phase_in = PH_DONE;
               emit = 1'b1;
            end else begin
               // Terminator tracking.
               if (data_byte == CH_CR) begin
                  term_in = (term_ff == 2'd2) ? 2'd3 : 2'd1;
               end else if (data_byte == CH_LF) begin
                  complete = (term_ff == 2'd3);
                  term_in = (term_ff == 2'd1) ? 2'd2 : 2'd0;
               end else begin
                  term_in = 2'd0;
               end
               if (phase_ff == PH_LINE) begin
                  if (line_ff == 16'hffff) lovf_in = 1'b1;
                  else line_in = line_ff + 16'd1;
                  if (prev_cr && data_byte == CH_LF) begin
                     if (spaces_ff != 2'd2 || ver_ff < 4'd6 || ver_ff == VER_MISS)
                        bad_in = 1'b1;
                     phase_in = PH_HDR;
                     hpos_in = '0; cl_in = 1'b1; te_in = 1'b1;
                  end else begin
                     if (prev_cr) bad_in = 1'b1;
                     if (data_byte == CH_LF) begin
                        bad_in = 1'b1;
                     end else if (data_byte == CH_SP) begin
                        case (spaces_ff)
                           2'd0: begin
                              if (meth_ff == 3'd0) bad_in = 1'b1;
                              spaces_in = 2'd1;
                           end
                           2'd1: begin
                              if (path_ff == 4'd0) bad_in = 1'b1;
                              spaces_in = 2'd2;
                           end
                           default: begin
                              bad_in = 1'b1;
                              spaces_in = 2'd3;
                           end
                        endcase
                     end else if (data_byte != CH_CR) begin
                        case (spaces_ff)
                           2'd0: meth_in = (meth_ff < 3'd3 && data_byte == get_char(meth_ff[1:0]))
                                 ? meth_ff + 3'd1 : METH_MISS;
                           2'd1: path_in = (path_ff < 4'd8 && data_byte == path_char(path_ff[2:0]))
                                 ? path_ff + 4'd1 : PATH_MISS;
                           2'd2: begin
                              if (ver_ff < 4'd5)
                                 ver_in = (data_byte == proto_char(ver_ff[2:0]))
                                    ? ver_ff + 4'd1 : VER_MISS;
                              else if (ver_ff == 4'd5)
                                 ver_in = (data_byte == 8'h31) ? 4'd6 : VER_OTHER;
                              else if (ver_ff == 4'd6)
                                 ver_in = (data_byte == 8'h2e) ? 4'd7 : VER_OTHER;
                              else if (ver_ff == 4'd7)
                                 ver_in = (data_byte == 8'h30 || data_byte == 8'h31)
                                    ? 4'd8 : VER_OTHER;
                              else if (ver_ff == 4'd8)
                                 ver_in = VER_OTHER;
                           end
                           default: ;
                        endcase
                     end
                  end
               end else begin
                  if (hdr_ff == 16'hffff) hovf_in = 1'b1;
                  else hdr_in = hdr_ff + 16'd1;
                  if (prev_cr && data_byte == CH_LF) begin
                     hpos_in = '0; cl_in = 1'b1; te_in = 1'b1;
                  end else begin
                     if (cl_ff && !(hpos_ff < 5'd14 && low == cl_char(hpos_ff))) begin
                        if (hpos_ff == 5'd14 && data_byte == 8'h3a) forb_in = 1'b1;
                        cl_in = 1'b0;
                     end
                     if (te_ff && !(hpos_ff < 5'd17 && low == te_char(hpos_ff))) begin
                        if (hpos_ff == 5'd17 && data_byte == 8'h3a) forb_in = 1'b1;
                        te_in = 1'b0;
                     end
                     if (hpos_ff != 5'd31) hpos_in = hpos_ff + 5'd1;
                  end
               end
               // Final verdict uses the updated state.
               if (complete) begin
                  emit = 1'b1;
                  phase_in = PH_DONE;
                  line_rej_nx = bad_in || lovf_in || (line_in > max_line);
                  if (line_rej_nx) verdict.status = ST_BAD;
                  else if (ver_in != 4'd8) verdict.status = ST_VERSION;
                  else if (hovf_in || hdr_in > max_hdr) verdict.status = ST_BAD;
                  else if (meth_in != 3'd3) verdict.status = ST_METHOD;
                  else if (forb_in) verdict.status = ST_BAD;
                  else if (path_in != 4'd8) verdict.status = ST_NOTFOUND;
                  else verdict.status = ST_OK;
               end
            end
         end
      end
   end

   // Connection state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE; total_ff <= '0; line_ff <= '0; hdr_ff <= '0;
         spaces_ff <= '0; meth_ff <= '0; path_ff <= '0; ver_ff <= '0;
         bad_ff <= 1'b0; lovf_ff <= 1'b0; hovf_ff <= 1'b0; cl_ff <= 1'b0; te_ff <= 1'b0;
         term_ff <= '0; hpos_ff <= '0; forb_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; total_ff <= total_in; line_ff <= line_in; hdr_ff <= hdr_in;
         spaces_ff <= spaces_in; meth_ff <= meth_in; path_ff <= path_in; ver_ff <= ver_in;
         bad_ff <= bad_in; lovf_ff <= lovf_in; hovf_ff <= hovf_in; cl_ff <= cl_in;
         te_ff <= te_in; term_ff <= term_in; hpos_ff <= hpos_in; forb_ff <= forb_in;
      end
   end
endmodule
`default_nettype wire

// File: hdl/hgrc_queue.sv
`default_nettype none
module hgrc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hgrc_pkg::verdict_type push_data,
   output logic                   full,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hgrc_pkg::verdict_type  out_data
);
   import hgrc_pkg::*;

   verdict_type slot_ff [2];
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign pop = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign full = (count_ff == 2'd2);
   assign out_data = slot_ff[rptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in; rptr_ff <= rptr_in; count_ff <= count_in;
      end
   end

   // Payload slots.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// File: hdl/http_get_request_checker_core.sv
// Each verdict is registered into the queue and shows on rsp_ when it reaches the head.
// Throughput: one transfer per cycle while req_ready is high.
// A two-entry verdict queue feeds the response port; req_ready drops only when it is full.
// Reset (synchronous, active high) clears connection state and the queue and loads
// the limit registers with 1024 and 8192.
`default_nettype none
`include "http_get_request_checker_core_defines.svh"
module http_get_request_checker_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import hgrc_pkg::*;

   logic [15:0] max_line_ff, max_hdr_ff;
   logic        step, emit, full;
   verdict_type verdict, head;

   assign req_ready = !full;
   assign step = req_valid && req_ready;
   assign rsp_status = head.status;

   // Limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= 16'd1024;
         max_hdr_ff  <= 16'd8192;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MAX_LINE) max_line_ff <= csr_write_data;
         if (csr_index == CSR_MAX_HDR)  max_hdr_ff  <= csr_write_data;
      end
   end

   hgrc_front u_front (
      .clock(clock), .reset(reset), .step(step), .kind(req_kind),
      .data_byte(req_data_byte), .max_line(max_line_ff), .max_hdr(max_hdr_ff),
      .emit(emit), .verdict(verdict)
   );

   hgrc_queue u_queue (
      .clock(clock), .reset(reset), .push(emit), .push_data(verdict), .full(full),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(head)
   );

   `HGRC_ASSERT_IMPL(a_no_push_full, clock, reset, full, !emit, "verdict pushed into full queue")
   `HGRC_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_VERSION, "bad status")
   `HGRC_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid, "verdict lost")
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import hgrc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [1:0] KIND_NOISE = 2'd3;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [15:0] csr_write_data;

   http_get_request_checker_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Shadow of the limit registers and of the connection state.
   logic [15:0] lim_line, lim_hdr;
   phase_type   conn_phase;
   logic [16:0] total_cnt;
   logic [15:0] line_cnt, hdr_cnt;
   int          spaces, meth_pos, path_pos, ver_pos, term_prog, name_pos;
   bit          bad_syntax, line_ovf, hdr_ovf, cl_live, te_live, forbidden_seen;

   logic [2:0]  verdict_q[$];
   int          fail_count = 0;
   int          verdict_count = 0;
   int          byte_count = 0;
   int          cycles = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   bit          pin_on = 0;
   logic [2:0]  pin_status;
   logic [7:0]  msg_bytes[$];

   string get_txt = "GET";
   string path_txt = "/metrics";
   string proto_txt = "HTTP/";
   string cl_txt = "content-length";
   string te_txt = "transfer-encoding";

   always #6 clock = ~clock;

   task automatic clear_conn();
      conn_phase = PH_LINE;
      total_cnt = '0;
      line_cnt = '0;
      hdr_cnt = '0;
      spaces = 0;
      meth_pos = 0;
      path_pos = 0;
      ver_pos = 0;
      term_prog = 0;
      name_pos = 0;
      {bad_syntax, line_ovf, hdr_ovf, cl_live, te_live, forbidden_seen} = '0;
   endtask

   function automatic bit line_rejected();
      return bad_syntax || line_ovf || (line_cnt > lim_line);
   endfunction

   // Request line content byte: field splitting and token matching.
   task automatic line_char(input logic [7:0] b);
      if (b == " ") begin
         if (spaces == 0 && meth_pos == 0) bad_syntax = 1;
         if (spaces == 1 && path_pos == 0) bad_syntax = 1;
         if (spaces >= 2) bad_syntax = 1;
         spaces = (spaces >= 2) ? 3 : spaces + 1;
      end else if (spaces == 0) begin
         meth_pos = (meth_pos < 3 && b == get_txt[meth_pos]) ? meth_pos + 1 : 7;
      end else if (spaces == 1) begin
         path_pos = (path_pos < 8 && b == path_txt[path_pos]) ? path_pos + 1 : 15;
      end else if (spaces == 2) begin
         if (ver_pos < 5) ver_pos = (b == proto_txt[ver_pos]) ? ver_pos + 1 : 15;
         else if (ver_pos == 5) ver_pos = (b == "1") ? 6 : 9;
         else if (ver_pos == 6) ver_pos = (b == ".") ? 7 : 9;
         else if (ver_pos == 7) ver_pos = (b == "0" || b == "1") ? 8 : 9;
         else if (ver_pos == 8) ver_pos = 9;
      end
   endtask

   // Header byte: case-insensitive match of the two forbidden names.
   task automatic header_char(input logic [7:0] b);
      logic [7:0] low;
      low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (cl_live && !(name_pos < 14 && low == cl_txt[name_pos])) begin
         if (name_pos == 14 && b == ":") forbidden_seen = 1;
         cl_live = 0;
      end
      if (te_live && !(name_pos < 17 && low == te_txt[name_pos])) begin
         if (name_pos == 17 && b == ":") forbidden_seen = 1;
         te_live = 0;
      end
      if (name_pos < 31) name_pos++;
   endtask

   function automatic logic [2:0] request_verdict();
      if (line_rejected()) return ST_BAD;
      if (ver_pos != 8) return ST_VERSION;
      if (hdr_ovf || hdr_cnt > lim_hdr) return ST_BAD;
      if (meth_pos != 3) return ST_METHOD;
      if (forbidden_seen) return ST_BAD;
      if (path_pos != 8) return ST_NOTFOUND;
      return ST_OK;
   endfunction

   // Works out the verdict, if any, that one transfer causes.
   task automatic predict_verdict(input logic [1:0] k, input logic [7:0] b,
                                  output bit got, output logic [2:0] st);
      bit prev_cr;
      bit complete;
      got = 0;
      st = ST_OK;
      complete = 0;
      if (k == KIND_CLOSE || k == KIND_ERROR) begin
         if (conn_phase != PH_DONE) begin
            got = 1;
            if (k == KIND_ERROR || conn_phase != PH_HDR || line_rejected()) st = ST_BAD;
            else st = (ver_pos != 8) ? ST_VERSION : ST_BAD;
         end
         clear_conn();
         return;
      end
      if (k == KIND_NOISE || conn_phase == PH_DONE) return;
      if (total_cnt < 17'h1ffff) total_cnt++;
      if (total_cnt > {1'b0, lim_line} + {1'b0, lim_hdr}) begin
         conn_phase = PH_DONE;
         got = 1;
         st = ST_BAD;
         return;
      end
      prev_cr = term_prog[0];
      if (b == CH_CR) begin
         term_prog = (term_prog == 2) ? 3 : 1;
      end else if (b == CH_LF) begin
         complete = (term_prog == 3);
         term_prog = (term_prog == 1) ? 2 : 0;
      end else begin
         term_prog = 0;
      end
      if (conn_phase == PH_LINE) begin
         if (line_cnt == 16'hffff) line_ovf = 1;
         else line_cnt++;
         if (prev_cr && b == CH_LF) begin
            if (spaces != 2 || ver_pos < 6 || ver_pos == 15) bad_syntax = 1;
            conn_phase = PH_HDR;
            name_pos = 0;
            cl_live = 1;
            te_live = 1;
         end else begin
            if (prev_cr || b == CH_LF) bad_syntax = 1;
            if (b != CH_LF && b != CH_CR) line_char(b);
         end
      end else begin
         if (hdr_cnt == 16'hffff) hdr_ovf = 1;
         else hdr_cnt++;
         if (prev_cr && b == CH_LF) begin
            name_pos = 0;
            cl_live = 1;
            te_live = 1;
         end else begin
            header_char(b);
         end
      end
      if (complete) begin
         got = 1;
         st = request_verdict();
         conn_phase = PH_DONE;
      end
   endtask

   // Sends one transfer; called and returns at a falling edge.
   task automatic send_item(input logic [1:0] k, input logic [7:0] b);
      bit got;
      logic [2:0] st;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_kind = k;
      req_data_byte = b;
      do @(posedge clock); while (!req_ready);
      predict_verdict(k, b, got, st);
      if (got) verdict_q.push_back(pin_on ? pin_status : st);
      if (k != KIND_NOISE) byte_count++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_limit(input logic [0:0] idx, input logic [15:0] val);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_enable = 0;
      if (idx == CSR_MAX_LINE) lim_line = val;
      else lim_hdr = val;
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) msg_bytes.push_back(s[i]);
   endtask

   task automatic add_crlf();
      msg_bytes.push_back(CH_CR);
      msg_bytes.push_back(CH_LF);
   endtask

   // Builds a mostly well-formed request with random choices and faults.
   task automatic build_request();
      string methods[4] = '{"GET", "POST", "GeT", "GETX"};
      string paths[5] = '{"/metrics", "/metrics", "/x", "/metricsx", "/"};
      string versions[6] = '{"HTTP/1.1", "HTTP/1.0", "HTTP/1.1", "HTTP/2", "HTTX/1.1",
                             "HTTP/1.10"};
      string headers[7] = '{"Host: a", "Accept: */*", "content-length: 5",
                            "Transfer-Encoding: chunked", "Content-Length5",
                            "TRANSFER-ENCODING :x", "X-A: b"};
      int n;
      msg_bytes.delete();
      if ($urandom_range(19) != 0) add_text(methods[$urandom_range(3)]);
      add_text(" ");
      if ($urandom_range(19) == 0) add_text(" ");
      if ($urandom_range(19) != 0) add_text(paths[$urandom_range(4)]);
      if ($urandom_range(9) != 0) add_text(" ");
      add_text(versions[$urandom_range(5)]);
      add_crlf();
      n = $urandom_range(3);
      repeat (n) begin
         add_text(headers[$urandom_range(6)]);
         add_crlf();
      end
      add_crlf();
      if ($urandom_range(9) == 0)
         msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
   endtask

   // Sends the built request, possibly cut short, then ends the connection.
   task automatic send_request();
      int cut;
      cut = ($urandom_range(7) == 0) ? $urandom_range(msg_bytes.size()) : msg_bytes.size();
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(49) == 0) send_item(KIND_NOISE, 8'($urandom_range(255)));
         send_item(KIND_DATA, msg_bytes[i]);
      end
      send_item(($urandom_range(3) == 0) ? KIND_ERROR : KIND_CLOSE, 8'($urandom_range(255)));
   endtask

   task automatic run_random(input int n_items, input int n_verdicts, input bit hold_off);
      int items_start, verdicts_start;
      items_start = byte_count;
      verdicts_start = verdict_count;
      while (byte_count - items_start < n_items || verdict_count - verdicts_start < n_verdicts)
      begin
         if ($urandom_range(9) == 0) begin
            // Raw noise transfers of any kind and value.
            repeat ($urandom_range(8, 1))
               send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
         end else begin
            build_request();
            send_request();
         end
         if (hold_off) begin
            hold_off = 0;
            req_valid = 0;
            while (verdict_q.size() != 0) @(negedge clock);
         end
      end
   endtask

   // Directed requests; the verdict is typed in where it is obvious.
   typedef struct {
      string      text;
      logic [1:0] tail;
      bit         has_exp;
      logic [2:0] exp_status;
   } directed_row;

   directed_row directed[16] = '{
      '{"GET /metrics HTTP/1.1\r\n\r\n", KIND_DATA, 1, ST_OK},
      '{"GET /metrics HTTP/1.0\r\nHost: a\r\n\r\n", KIND_DATA, 1, ST_OK},
      '{"POST /metrics HTTP/1.1\r\n\r\n", KIND_DATA, 1, ST_METHOD},
      '{"GET /x HTTP/1.1\r\n\r\n", KIND_DATA, 1, ST_NOTFOUND},
      '{"GET /metrics HTTP/2.0\r\n\r\n", KIND_DATA, 1, ST_VERSION},
      '{"GET /metrics HTTP/1.1\r\nContent-Length: 0\r\n\r\n", KIND_DATA, 1, ST_BAD},
      '{"GET /metrics HTTP/1.1\r\ntransfer-ENCODING:x\r\n\r\n", KIND_DATA, 1, ST_BAD},
      '{"GET /metrics HTTP/1.1\r\nContent-Lengthy: 1\r\n\r\n", KIND_DATA, 1, ST_OK},
      '{"GET  /metrics HTTP/1.1\r\n\r\n", KIND_DATA, 1, ST_BAD},
      '{"GET /metrics\r\n\r\n", KIND_DATA, 1, ST_BAD},
      '{"GET /met\rrics HTTP/1.1\r\n\r\n", KIND_DATA, 1, ST_BAD},
      '{"GET /metrics HTTP/1.1", KIND_CLOSE, 1, ST_BAD},
      '{"GET /metrics HTTP/3\r\n", KIND_CLOSE, 1, ST_VERSION},
      '{"GET /metrics HTTP/1.1\r\n", KIND_ERROR, 1, ST_BAD},
      '{"", KIND_CLOSE, 1, ST_BAD},
      '{"GET /metrics HTTP/1.1\r\n\r\nxyz", KIND_CLOSE, 0, ST_OK}
   };

   task automatic run_directed();
      foreach (directed[r]) begin
         msg_bytes.delete();
         add_text(directed[r].text);
         pin_status = directed[r].exp_status;
         foreach (msg_bytes[i]) begin
            pin_on = directed[r].has_exp && directed[r].tail == KIND_DATA &&
                     i == msg_bytes.size() - 1;
            send_item(KIND_DATA, msg_bytes[i]);
         end
         pin_on = directed[r].has_exp && directed[r].tail != KIND_DATA;
         send_item(directed[r].tail == KIND_DATA ? KIND_CLOSE : directed[r].tail, 8'hff);
         pin_on = 0;
      end
      send_item(KIND_NOISE, 8'h00);
   endtask

   // Result checking against the oldest expected verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected verdict transfer: status %0d", rsp_status);
            fail_count++;
         end else begin
            if (rsp_status !== verdict_q[0]) begin
               $error("status mismatch: expected %0d, actual %0d", verdict_q[0], rsp_status);
               fail_count++;
            end
            void'(verdict_q.pop_front());
            verdict_count++;
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_kind = KIND_DATA;
      req_data_byte = '0;
      rsp_ready = 0;
      csr_write_enable = 0;
      csr_index = CSR_MAX_LINE;
      csr_write_data = '0;
      lim_line = 16'd1024;
      lim_hdr = 16'd8192;
      clear_conn();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Phase one: reset limits, sender idles less than the receiver.
      req_idle_pct = 29;
      rsp_idle_pct = 65;
      run_directed();
      run_random(150, 12, 0);
      wait_idle();

      // Phase two: tight limits, roles of idling swapped.
      req_idle_pct = 65;
      rsp_idle_pct = 29;
      write_limit(CSR_MAX_LINE, 16'($urandom_range(60, 20)));
      write_limit(CSR_MAX_HDR, 16'($urandom_range(60, 2)));
      run_random(150, 12, 1);
      wait_idle();

      // Phase three: no idling; limits of 2, then the largest limits.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_limit(CSR_MAX_LINE, 16'd2);
      write_limit(CSR_MAX_HDR, 16'd2);
      run_random(40, 8, 0);
      wait_idle();
      write_limit(CSR_MAX_LINE, 16'hffff);
      write_limit(CSR_MAX_HDR, 16'hffff);
      run_random(100, 10, 0);

      // Drain and let the pipeline settle.
      req_valid = 0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/hgrc_pkg.sv
hdl/hgrc_front.sv
hdl/hgrc_queue.sv
hdl/http_get_request_checker_core.sv
tb/tb.sv
